### hw/rtl/dits_pkg.sv
// Shared types and constants of the dual interval timer status block.
// Used by dits_ctrl, dits_dp and dual_interval_timer_status; depends on nothing else.

package dits_pkg;

	// Field widths
	localparam int CMD_W = 3;
	localparam int DATA_W = 8;
	localparam int CYC_W = 12;
	localparam int CPT_W = 20;
	localparam int STATUS_W = 8;
	localparam int FRAC_BITS_DEF = 8;

	// Reload values in whole master cycles
	localparam int RLA_W = 22;
	localparam int RLB_W = 24;

	localparam logic [CPT_W-1:0] CPT_RESET = 20'd44121;
	localparam logic [CPT_W-1:0] TICK_MIN = 20'd256;

	// Bus command codes
	localparam logic [CMD_W-1:0] CMD_SEL_I = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DATA_I = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADV = 3'd5;

	// Register numbers
	localparam logic [DATA_W-1:0] REG_TA_HIGH = 8'h24;
	localparam logic [DATA_W-1:0] REG_TA_LOW = 8'h25;
	localparam logic [DATA_W-1:0] REG_TB = 8'h26;
	localparam logic [DATA_W-1:0] REG_MODE = 8'h27;
	localparam logic [DATA_W-1:0] REG_DAC = 8'h2A;

	// Mode register bits
	localparam int MODE_LOAD_A = 0;
	localparam int MODE_LOAD_B = 1;
	localparam int MODE_EN_A = 2;
	localparam int MODE_EN_B = 3;
	localparam int MODE_CLR_A = 4;
	localparam int MODE_CLR_B = 5;

	// Period arithmetic: ticks times 136.8, i.e. times 1368 then divided by 10
	localparam int PER_W = 17;
	localparam logic [10:0] A_BASE = 11'd1024;
	localparam logic [8:0] B_BASE = 9'd256;
	localparam logic [PER_W-1:0] A_TICKS = 17'd18;
	localparam logic [PER_W-1:0] B_TICKS = 17'd288;
	localparam int SC_W = 27;
	localparam logic [SC_W-1:0] SCALE_MUL = 27'd1368;
	// Reciprocal of ten, exact for every dividend below 2^30
	localparam int RECIP_W = 28;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_M = 28'd214748365;
	localparam int PR_W = SC_W + RECIP_W;

	typedef struct packed {
		logic load_item;
		logic set_select;
		logic write_reg;
		logic scale_load;
		logic scale_sel_b;
		logic scale_mul;
		logic commit_a;
		logic commit_b;
		logic adv_add;
		logic adv_tick;
		logic out_load;
	} dits_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic sel_mode;
		logic accum_pos;
	} dits_sts_t;

endpackage

### hw/rtl/dual_interval_timer_status.sv
// Dual interval timer status: an item is accepted only while the block is idle. A select
// or plain register write goes from decode to its result beat, a timer mode write first
// passes through the shared reload scaling pipe (states MA to MD), and a time advance
// steps the counters one sample period per cycle while the cycle balance stays positive.
// The result waits in an output register, so a stalled output holds the next item.
// arst_n clears all timer state and sets the tick period to 44121.

module dual_interval_timer_status #(
	parameter int FRAC_BITS = dits_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dits_pkg::CPT_W-1:0]    cfg_wdata,  // cycles_per_tick
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,    // data [7:0], cycles [19:8], zero [23:20]
	input  logic [dits_pkg::CMD_W-1:0]    s_tuser,    // cmd [2:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dits_pkg::STATUS_W-1:0] m_tdata     // status [7:0]
);

	dits_pkg::dits_ctl_t ctl;
	dits_pkg::dits_sts_t sts;

	dits_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	dits_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_cmd    (s_tuser),
		.in_data   (s_tdata[7:0]),
		.in_cycles (s_tdata[19:8]),
		.ctl       (ctl),
		.sts       (sts),
		.status    (m_tdata)
	);

endmodule

### hw/rtl/dits_ctrl.sv
// Sequencing controller of the dual interval timer status block.
// Depends on dits_pkg; drives dits_dp through a command struct.

module dits_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  dits_pkg::dits_sts_t sts,
	output dits_pkg::dits_ctl_t ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_MA   = 3'd2;
	localparam logic [2:0] ST_MB   = 3'd3;
	localparam logic [2:0] ST_MC   = 3'd4;
	localparam logic [2:0] ST_MD   = 3'd5;
	localparam logic [2:0] ST_TICK = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		ctl = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.load_item = 1'b1;
					state_nxt = ST_DEC;
				end
			end
			ST_DEC: begin
				priority if (sts.item_cmd == dits_pkg::CMD_SEL_I) begin
					ctl.set_select = 1'b1;
					state_nxt = ST_DONE;
				end else if (sts.item_cmd == dits_pkg::CMD_DATA_I && sts.sel_mode) begin
					state_nxt = ST_MA;
				end else if (sts.item_cmd == dits_pkg::CMD_DATA_I) begin
					ctl.write_reg = 1'b1;
					state_nxt = ST_DONE;
				end else if (sts.item_cmd == dits_pkg::CMD_ADV) begin
					ctl.adv_add = 1'b1;
					state_nxt = ST_TICK;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			// The two reload values share one scaling pipe, timer B following timer A through it.
			ST_MA: begin
				ctl.scale_load = 1'b1;
				state_nxt = ST_MB;
			end
			ST_MB: begin
				ctl.scale_mul = 1'b1;
				ctl.scale_load = 1'b1;
				ctl.scale_sel_b = 1'b1;
				state_nxt = ST_MC;
			end
			ST_MC: begin
				ctl.commit_a = 1'b1;
				ctl.scale_mul = 1'b1;
				state_nxt = ST_MD;
			end
			ST_MD: begin
				ctl.commit_b = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_TICK: begin
				if (sts.accum_pos) begin
					ctl.adv_tick = 1'b1;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					ctl.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/dits_dp.sv
// Datapath of the dual interval timer status block: registers, reload scaling,
// counters and cycle balance. Depends on dits_pkg; commanded by dits_ctrl.

module dits_dp #(
	parameter int FRAC_BITS = dits_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dits_pkg::CPT_W-1:0]          cfg_wdata,
	input  logic [dits_pkg::CMD_W-1:0]          in_cmd,
	input  logic [dits_pkg::DATA_W-1:0]         in_data,
	input  logic [dits_pkg::CYC_W-1:0]          in_cycles,
	input  dits_pkg::dits_ctl_t                 ctl,
	output dits_pkg::dits_sts_t                 sts,
	output logic [dits_pkg::STATUS_W-1:0]       status
);

	localparam int CA_W = dits_pkg::RLA_W + FRAC_BITS + 1;
	localparam int CB_W = dits_pkg::RLB_W + FRAC_BITS + 1;
	localparam int ADD_W = dits_pkg::CYC_W + FRAC_BITS;
	localparam int ACC_W = ((ADD_W > dits_pkg::CPT_W) ? ADD_W : dits_pkg::CPT_W) + 2;

	logic [dits_pkg::CMD_W-1:0]  cmd_q;
	logic [dits_pkg::DATA_W-1:0] data_q;
	logic [dits_pkg::CYC_W-1:0]  cycles_q;

	logic [dits_pkg::CPT_W-1:0]  cpt_q;
	logic [dits_pkg::DATA_W-1:0] reg_select_q;
	logic [7:0]                  ta_high_q;
	logic [1:0]                  ta_low_q;
	logic [7:0]                  tb_per_q;
	logic [dits_pkg::DATA_W-1:0] mode_q;
	logic                        busy_q;
	logic                        ova_q;
	logic                        ovb_q;
	logic [dits_pkg::RLA_W-1:0]  reload_a_q;
	logic [dits_pkg::RLB_W-1:0]  reload_b_q;
	logic signed [CA_W-1:0]      count_a_q;
	logic signed [CB_W-1:0]      count_b_q;
	logic signed [ACC_W-1:0]     accum_q;

	logic [dits_pkg::SC_W-1:0]   scale_s1;
	logic [dits_pkg::PR_W-1:0]   prod_s2;
	logic [dits_pkg::STATUS_W-1:0] status_q;

	logic [10:0]                 a_span;
	logic [8:0]                  b_span;
	logic [dits_pkg::PER_W-1:0]  per_a;
	logic [dits_pkg::PER_W-1:0]  per_b;
	logic [dits_pkg::PER_W-1:0]  per_sel;
	logic [dits_pkg::RLB_W-1:0]  scaled;
	logic [dits_pkg::CPT_W-1:0]  tick;
	logic signed [CA_W-1:0]      count_a_dec;
	logic signed [CB_W-1:0]      count_b_dec;
	logic signed [CA_W-1:0]      fix_a;
	logic signed [CB_W-1:0]      fix_b;
	logic                        run_a;
	logic                        run_b;
	logic                        exp_a;
	logic                        exp_b;

	assign a_span = dits_pkg::A_BASE - {1'b0, ta_high_q, ta_low_q};
	assign b_span = dits_pkg::B_BASE - {1'b0, tb_per_q};
	assign per_a = dits_pkg::PER_W'(dits_pkg::PER_W'(a_span) * dits_pkg::A_TICKS);
	assign per_b = dits_pkg::PER_W'(dits_pkg::PER_W'(b_span) * dits_pkg::B_TICKS);
	assign per_sel = ctl.scale_sel_b ? per_b : per_a;
	// Floor of the scaled product divided by ten.
	assign scaled = prod_s2[dits_pkg::RECIP_SHIFT +: dits_pkg::RLB_W];

	assign tick = (cpt_q < dits_pkg::TICK_MIN) ? dits_pkg::TICK_MIN : cpt_q;

	assign fix_a = $signed({1'b0, reload_a_q, {FRAC_BITS{1'b0}}});
	assign fix_b = $signed({1'b0, reload_b_q, {FRAC_BITS{1'b0}}});
	assign count_a_dec = count_a_q - $signed({{(CA_W - dits_pkg::CPT_W){1'b0}}, tick});
	assign count_b_dec = count_b_q - $signed({{(CB_W - dits_pkg::CPT_W){1'b0}}, tick});
	assign run_a = !count_a_q[CA_W-1] && (count_a_q != '0);
	assign run_b = !count_b_q[CB_W-1] && (count_b_q != '0);
	assign exp_a = count_a_dec[CA_W-1] || (count_a_dec == '0);
	assign exp_b = count_b_dec[CB_W-1] || (count_b_dec == '0);

	assign sts.item_cmd = cmd_q;
	assign sts.sel_mode = (reg_select_q == dits_pkg::REG_MODE);
	assign sts.accum_pos = !accum_q[ACC_W-1] && (accum_q != '0);
	assign status = status_q;

	// Item and pipeline registers carry no reset.
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= in_cmd;
			data_q <= in_data;
			cycles_q <= in_cycles;
		end
		if (ctl.scale_load) begin
			scale_s1 <= dits_pkg::SC_W'(dits_pkg::SC_W'(per_sel) * dits_pkg::SCALE_MUL);
		end
		if (ctl.scale_mul) begin
			prod_s2 <= dits_pkg::PR_W'(scale_s1) * dits_pkg::PR_W'(dits_pkg::RECIP_M);
		end
		if (ctl.out_load) begin
			status_q <= {busy_q, 5'b0, ova_q, ovb_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpt_q <= dits_pkg::CPT_RESET;
			reg_select_q <= '0;
			ta_high_q <= '0;
			ta_low_q <= '0;
			tb_per_q <= '0;
			mode_q <= '0;
			busy_q <= 1'b0;
			ova_q <= 1'b0;
			ovb_q <= 1'b0;
			reload_a_q <= '0;
			reload_b_q <= '0;
			count_a_q <= '0;
			count_b_q <= '0;
			accum_q <= '0;
		end else begin
			if (cfg_we) begin
				cpt_q <= cfg_wdata;
			end
			if (ctl.set_select) begin
				reg_select_q <= data_q;
			end
			if (ctl.write_reg) begin
				unique case (reg_select_q)
					dits_pkg::REG_TA_HIGH: ta_high_q <= data_q;
					dits_pkg::REG_TA_LOW:  ta_low_q <= data_q[1:0];
					dits_pkg::REG_TB:      tb_per_q <= data_q;
					dits_pkg::REG_DAC:     busy_q <= 1'b1;
					default: begin
					end
				endcase
			end
			if (ctl.commit_a) begin
				if (data_q[dits_pkg::MODE_LOAD_A]) begin
					reload_a_q <= scaled[dits_pkg::RLA_W-1:0];
					count_a_q <= $signed({1'b0, scaled[dits_pkg::RLA_W-1:0],
						{FRAC_BITS{1'b0}}});
				end else begin
					reload_a_q <= '0;
					count_a_q <= '0;
				end
			end
			if (ctl.commit_b) begin
				mode_q <= data_q;
				if (data_q[dits_pkg::MODE_LOAD_B]) begin
					reload_b_q <= scaled;
					count_b_q <= $signed({1'b0, scaled, {FRAC_BITS{1'b0}}});
				end else begin
					reload_b_q <= '0;
					count_b_q <= '0;
				end
				if (data_q[dits_pkg::MODE_CLR_A]) begin
					ova_q <= 1'b0;
				end
				if (data_q[dits_pkg::MODE_CLR_B]) begin
					ovb_q <= 1'b0;
				end
			end
			if (ctl.adv_add) begin
				accum_q <= accum_q + $signed({{(ACC_W - ADD_W){1'b0}}, cycles_q,
					{FRAC_BITS{1'b0}}});
			end
			// One sample period: only running counters move, an expired one reloads, busy clears and the balance drops.
			if (ctl.adv_tick) begin
				if (run_a) begin
					if (exp_a) begin
						count_a_q <= fix_a;
						if (mode_q[dits_pkg::MODE_EN_A]) begin
							ova_q <= 1'b1;
						end
					end else begin
						count_a_q <= count_a_dec;
					end
				end
				if (run_b) begin
					if (exp_b) begin
						count_b_q <= fix_b;
						if (mode_q[dits_pkg::MODE_EN_B]) begin
							ovb_q <= 1'b1;
						end
					end else begin
						count_b_q <= count_b_dec;
					end
				end
				busy_q <= 1'b0;
				accum_q <= accum_q - $signed({{(ACC_W - dits_pkg::CPT_W){1'b0}}, tick});
			end
		end
	end

endmodule

### tb/tb_dual_interval_timer_status.sv
// Self-checking testbench for dual_interval_timer_status: every accepted bus beat is
// fed to a behavioural model of the timers, and each status beat is checked against it.
// Depends on dits_pkg and the dual_interval_timer_status RTL only.
`timescale 1ns / 100ps

module tb_dual_interval_timer_status;

	localparam logic [dits_pkg::CMD_W-1:0] CMD_SEL_II = 3'd2;
	localparam logic [dits_pkg::CMD_W-1:0] CMD_DATA_II = 3'd3;
	localparam logic [dits_pkg::CMD_W-1:0] CMD_RD_STATUS = 3'd4;
	localparam logic [dits_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [dits_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	localparam int STS_BUSY = 7;
	localparam int STS_OVA = 1;
	localparam int STS_OVB = 0;

	localparam int FRAC = dits_pkg::FRAC_BITS_DEF;
	localparam longint TIMEOUT_NS = 64'd50_000_000;

	typedef struct packed {
		logic [dits_pkg::CMD_W-1:0]  cmd;
		logic [dits_pkg::DATA_W-1:0] data;
		logic [dits_pkg::CYC_W-1:0]  cycles;
		logic                        drain;
	} bus_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [dits_pkg::CPT_W-1:0]    cfg_wdata = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [23:0]                   s_tdata = '0;    // data [7:0], cycles [19:8], zero [23:20]
	logic [dits_pkg::CMD_W-1:0]    s_tuser = '0;    // cmd [2:0]
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [dits_pkg::STATUS_W-1:0] m_tdata;         // status [7:0]

	bus_item_t           pending_q[$];
	logic [7:0]          due_status_q[$];
	bus_item_t           cur_beat;
	logic                drain_next = 1'b0;
	int                  fail_count = 0;
	int                  send_gap, send_calm, recv_stall, recv_calm;

	// Timer state as the block should hold it
	logic [dits_pkg::CPT_W-1:0] tick_cfg = dits_pkg::CPT_RESET;
	logic [7:0]          sel_reg = '0, ta_high = '0, tb_per = '0, mode_reg = '0;
	logic [1:0]          ta_low = '0;
	logic                busy = 1'b0, ov_a = 1'b0, ov_b = 1'b0;
	longint              reload_a = 0, reload_b = 0, cnt_a = 0, cnt_b = 0, accum = 0;

	dual_interval_timer_status i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one accepted bus beat to the timer state and returns the status after it.
	task automatic apply_bus_beat(input bus_item_t it, output logic [7:0] status);
		longint step_len;
		longint ticks;
		step_len = (tick_cfg < dits_pkg::TICK_MIN) ? longint'(dits_pkg::TICK_MIN)
			: longint'(tick_cfg);
		case (it.cmd)
		dits_pkg::CMD_SEL_I: sel_reg = it.data;
		dits_pkg::CMD_DATA_I: begin
			case (sel_reg)
			dits_pkg::REG_TA_HIGH: ta_high = it.data;
			dits_pkg::REG_TA_LOW: ta_low = it.data[1:0];
			dits_pkg::REG_TB: tb_per = it.data;
			dits_pkg::REG_MODE: begin
				mode_reg = it.data;
				// Periods are in chip ticks of 136.8 master cycles, rounded down.
				if (it.data[dits_pkg::MODE_LOAD_A]) begin
					ticks = 18 * (1024 - longint'({ta_high, ta_low}));
					reload_a = ticks * 1368 / 10;
				end else begin
					reload_a = 0;
				end
				if (it.data[dits_pkg::MODE_LOAD_B]) begin
					ticks = 288 * (256 - longint'(tb_per));
					reload_b = ticks * 1368 / 10;
				end else begin
					reload_b = 0;
				end
				cnt_a = reload_a << FRAC;
				cnt_b = reload_b << FRAC;
				if (it.data[dits_pkg::MODE_CLR_A])
					ov_a = 1'b0;
				if (it.data[dits_pkg::MODE_CLR_B])
					ov_b = 1'b0;
			end
			dits_pkg::REG_DAC: busy = 1'b1;
			default: ;
			endcase
		end
		dits_pkg::CMD_ADV: begin
			accum += longint'(it.cycles) << FRAC;
			while (accum > 0) begin
				if (cnt_a > 0) begin
					cnt_a -= step_len;
					if (cnt_a <= 0) begin
						if (mode_reg[dits_pkg::MODE_EN_A])
							ov_a = 1'b1;
						cnt_a = reload_a << FRAC;
					end
				end
				if (cnt_b > 0) begin
					cnt_b -= step_len;
					if (cnt_b <= 0) begin
						if (mode_reg[dits_pkg::MODE_EN_B])
							ov_b = 1'b1;
						cnt_b = reload_b << FRAC;
					end
				end
				busy = 1'b0;
				accum -= step_len;
			end
		end
		default: ;
		endcase
		status = '0;
		status[STS_BUSY] = busy;
		status[STS_OVA] = ov_a;
		status[STS_OVB] = ov_b;
	endtask

	// Sender: one beat per pending item, with a drawn gap after each acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
			send_calm <= 0;
		end else begin : drive
			bus_item_t it;
			logic [7:0] status;
			int g;
			logic go;
			if (s_tvalid && s_tready) begin
				apply_bus_beat(cur_beat, status);
				due_status_q.push_back(status);
			end
			if (!s_tvalid || s_tready) begin
				go = 1'b0;
				if (send_gap == 0 && pending_q.size() != 0)
					go = !(pending_q[0].drain && due_status_q.size() != 0);
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (go) begin
					it = pending_q.pop_front();
					cur_beat <= it;
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, it.cycles, it.data};
					s_tuser <= it.cmd;
					if (send_calm > 0) begin
						g = 0;
						send_calm <= send_calm - 1;
					end else if ($urandom_range(0, 19) == 0) begin
						g = 0;
						send_calm <= $urandom_range(10, 40);
					end else begin
						g = $urandom_range(0, 15);
					end
					send_gap <= g;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each status beat and stalls for a drawn number of cycles after it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
			recv_calm <= 0;
		end else begin : watch
			logic [7:0] want;
			int n;
			n = recv_stall;
			if (m_tvalid && m_tready) begin
				if (due_status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected status beat %02h at %0t", m_tdata, $realtime);
				end else begin
					want = due_status_q.pop_front();
					if (m_tdata !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("status mismatch at %0t: expected %02h, got %02h",
								$realtime, want, m_tdata);
					end
				end
				if (recv_calm > 0) begin
					n = 0;
					recv_calm <= recv_calm - 1;
				end else if ($urandom_range(0, 19) == 0) begin
					n = 0;
					recv_calm <= $urandom_range(10, 40);
				end else begin
					n = $urandom_range(0, 15);
				end
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				recv_stall <= n - 1;
			end else begin
				m_tready <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	task automatic push_beat(input logic [dits_pkg::CMD_W-1:0] cmd,
		input logic [dits_pkg::DATA_W-1:0] data, input logic [dits_pkg::CYC_W-1:0] cycles);
		bus_item_t it;
		it.cmd = cmd;
		it.data = data;
		it.cycles = cycles;
		it.drain = drain_next;
		pending_q.push_back(it);
		drain_next = 1'b0;
	endtask

	task automatic write_reg(input logic [dits_pkg::DATA_W-1:0] regnum,
		input logic [dits_pkg::DATA_W-1:0] value);
		push_beat(dits_pkg::CMD_SEL_I, regnum, 12'($urandom_range(0, 4095)));
		push_beat(dits_pkg::CMD_DATA_I, value, 12'($urandom_range(0, 4095)));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || s_tvalid || due_status_q.size() != 0);
	endtask

	task automatic write_tick(input logic [dits_pkg::CPT_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tick_cfg = value;
		@(negedge clk);
	endtask

	// Short periods see long advances only rarely, or beats would run thousands of periods.
	function automatic logic [dits_pkg::CYC_W-1:0] draw_cycles(input int cap);
		if ($urandom_range(0, 49) == 0)
			return 12'hFFF;
		if ($urandom_range(0, 9) == 0)
			return 12'h000;
		if (cap >= 4095 && $urandom_range(0, 1) == 1)
			return 12'($urandom_range(3072, 4095));
		return 12'($urandom_range(0, cap));
	endfunction

	task automatic random_phase(input int target, input int cap);
		int made;
		int pick;
		logic [7:0] v;
		made = 0;
		drain_next = 1'b1;
		while (made < target) begin
			if ($urandom_range(0, 149) == 0)
				drain_next = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				push_beat(dits_pkg::CMD_ADV, 8'($urandom_range(0, 255)), draw_cycles(cap));
				made++;
			end else if (pick < 75) begin
				pick = $urandom_range(0, 99);
				v = 8'($urandom_range(0, 255));
				// Timer periods are kept mostly short so that overflows do occur.
				if (pick < 20) begin
					if ($urandom_range(0, 3) != 0)
						v = 8'($urandom_range(252, 255));
					write_reg(dits_pkg::REG_TA_HIGH, v);
				end else if (pick < 35) begin
					write_reg(dits_pkg::REG_TA_LOW, v);
				end else if (pick < 55) begin
					if ($urandom_range(0, 3) != 0)
						v = 8'($urandom_range(252, 255));
					write_reg(dits_pkg::REG_TB, v);
				end else if (pick < 67) begin
					if ($urandom_range(0, 3) != 0) begin
						v[dits_pkg::MODE_LOAD_A] = 1'b1;
						v[dits_pkg::MODE_LOAD_B] = 1'b1;
					end
					write_reg(dits_pkg::REG_MODE, v);
				end else if (pick < 82) begin
					write_reg(dits_pkg::REG_DAC, v);
				end else begin
					write_reg(8'($urandom_range(0, 255)), v);
				end
				made += 2;
			end else if (pick < 83) begin
				push_beat(CMD_RD_STATUS, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
				made++;
			end else if (pick < 92) begin
				// Stray beat of any kind, which also breaks select and data pairs.
				v = 8'($urandom_range(0, 7));
				push_beat(v[2:0], 8'($urandom_range(0, 255)),
					(v[2:0] == dits_pkg::CMD_ADV) ? draw_cycles(cap)
					: 12'($urandom_range(0, 4095)));
				made++;
			end else begin
				case ($urandom_range(0, 3))
				0: v[2:0] = CMD_SEL_II;
				1: v[2:0] = CMD_DATA_II;
				2: v[2:0] = CMD_SPARE_6;
				default: v[2:0] = CMD_SPARE_7;
				endcase
				push_beat(v[2:0], 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
				made++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Shortest timer periods, the low byte of timer A given with its upper bits set.
		write_reg(dits_pkg::REG_TA_HIGH, 8'hFF);
		write_reg(dits_pkg::REG_TA_LOW, 8'hFF);
		write_reg(dits_pkg::REG_TB, 8'hFF);
		// Part II beats must not disturb part I.
		push_beat(CMD_SEL_II, dits_pkg::REG_MODE, 12'h000);
		push_beat(CMD_DATA_II, 8'h00, 12'h000);
		write_reg(dits_pkg::REG_MODE, 8'h0F);
		push_beat(CMD_RD_STATUS, 8'h00, 12'hFFF);
		repeat (10)
			push_beat(dits_pkg::CMD_ADV, 8'h00, 12'hFFF);
		write_reg(dits_pkg::REG_DAC, 8'h5A);
		push_beat(dits_pkg::CMD_ADV, 8'hFF, 12'h000);
		write_reg(dits_pkg::REG_MODE, 8'h30);

		write_tick(20'hFFFFF);
		random_phase(200, 4095);
		write_tick(20'd256);
		random_phase(150, 200);
		write_tick(20'd0);
		random_phase(100, 200);
		write_tick(20'($urandom_range(4096, 1048575)));
		random_phase(250, 4095);
		write_tick(dits_pkg::CPT_RESET);
		random_phase(400, 4095);
		write_tick(20'($urandom_range(257, 4095)));
		random_phase(100, 255);

		wait_drained();
		repeat (40) @(posedge clk);
		if (due_status_q.size() != 0) begin
			fail_count++;
			$display("%0d status beats never arrived", due_status_q.size());
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
